[rtl/core/ifd_pkg.sv]
// Shared types and constants for the information frame deframer.
`timescale 1ns / 1ps

package ifd_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;
	localparam logic [7:0] CTRL_INFO = 8'd0;
	localparam logic [7:0] CTRL_DISC = 8'd11;

	localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
	localparam logic [1:0] KIND_FRAME_GOOD = 2'd1;
	localparam logic [1:0] KIND_FRAME_BAD  = 2'd2;
	localparam logic [1:0] KIND_DISCONNECT = 2'd3;

	typedef enum logic [2:0] {
		ST_WAIT_FLAG = 3'd0,
		ST_ADDR      = 3'd1,
		ST_CTRL      = 3'd2,
		ST_BCC1      = 3'd3,
		ST_DATA      = 3'd4,
		ST_DISC_BCC  = 3'd5,
		ST_DISC_FLAG = 3'd6
	} hdr_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} result_t;

endpackage

[rtl/core/info_frame_deframer.sv]
// Top level of the information frame deframer: header match, destuffing and result queue.
`timescale 1ns / 1ps

// Usage: raw line bytes enter on rx_byte with in_valid/in_ready; each request
// is one byte. Results leave on kind, payload_byte and last with
// out_valid/out_ready; one input byte causes zero, one or two results, and
// last marks the final result of each byte. Destuffed payload bytes are
// released one byte late, so the check byte of a frame never appears as
// payload; the closing flag reports the frame good or bad, and a disconnect
// header followed by a flag reports a disconnect.
// A byte is registered at acceptance and decoded once the queue has room;
// its results are written to the queue at the end of the decode cycle and
// are then visible at the output.
// Throughput: one byte per cycle while the queue has room; the rate is set by the
// single decode stage and by the output side taking one result per cycle. The
// four-entry result queue must have room for two results before a byte is decoded.
// The address register is written with cfg_we/cfg_data and resets to 3.
// Reset clears the header state, the delay stage, the running XOR and the
// queue. When the receiver stalls, results wait in the queue and in_ready
// drops once the input register holds a byte and the queue has room for
// fewer than two results; nothing is lost.
module info_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic       last
);
	import ifd_pkg::*;

	logic [7:0] address_q;

	logic       in_valid_s1;
	logic [7:0] rx_byte_s1;

	hdr_state_t hdr_q, hdr_d;
	logic       esc_q, esc_d;
	logic [7:0] held_q, held_d;
	logic       held_valid_q, held_valid_d;
	logic [7:0] xor_q, xor_d;

	result_t    res_d [2];
	logic [1:0] n_res;

	result_t    queue_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	logic pop;
	logic room;
	logic fire;

	assign pop       = out_valid && out_ready;
	assign room      = (count_q < 3'd3) || ((count_q == 3'd3) && pop);
	assign fire      = in_valid_s1 && room;
	assign in_ready  = !in_valid_s1 || fire;
	assign out_valid = (count_q != 3'd0);

	assign kind         = queue_q[rd_ptr_q].kind;
	assign payload_byte = queue_q[rd_ptr_q].data;
	assign last         = queue_q[rd_ptr_q].last;

	always_comb begin
		unique case (hdr_q)
			ST_ADDR: begin
				priority if (rx_byte_s1 == address_q) hdr_d = ST_CTRL;
				else if (rx_byte_s1 == FLAG_BYTE) hdr_d = ST_ADDR;
				else hdr_d = ST_WAIT_FLAG;
			end
			ST_CTRL: begin
				priority if (rx_byte_s1 == CTRL_INFO) hdr_d = ST_BCC1;
				else if (rx_byte_s1 == CTRL_DISC) hdr_d = ST_DISC_BCC;
				else if (rx_byte_s1 == FLAG_BYTE) hdr_d = ST_ADDR;
				else hdr_d = ST_WAIT_FLAG;
			end
			ST_BCC1: begin
				priority if (rx_byte_s1 == (address_q ^ CTRL_INFO)) hdr_d = ST_DATA;
				else if (rx_byte_s1 == FLAG_BYTE) hdr_d = ST_ADDR;
				else hdr_d = ST_WAIT_FLAG;
			end
			ST_DATA: begin
				hdr_d = (rx_byte_s1 == FLAG_BYTE) ? ST_WAIT_FLAG : ST_DATA;
			end
			ST_DISC_BCC: begin
				priority if (rx_byte_s1 == (address_q ^ CTRL_DISC)) hdr_d = ST_DISC_FLAG;
				else if (rx_byte_s1 == FLAG_BYTE) hdr_d = ST_ADDR;
				else hdr_d = ST_WAIT_FLAG;
			end
			ST_DISC_FLAG: begin
				hdr_d = ST_WAIT_FLAG;
			end
			default: begin
				hdr_d = (rx_byte_s1 == FLAG_BYTE) ? ST_ADDR : ST_WAIT_FLAG;
			end
		endcase
	end

	// Each call of the delay stage releases the held byte, if any, and holds
	// the new one; an escape followed by a plain byte calls it twice.
	always_comb begin
		esc_d        = esc_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		xor_d        = xor_q;
		n_res        = 2'd0;
		res_d[0]     = '0;
		res_d[1]     = '0;
		unique case (hdr_q)
			ST_BCC1: begin
				if (rx_byte_s1 == (address_q ^ CTRL_INFO)) begin
					esc_d        = 1'b0;
					held_d       = 8'd0;
					held_valid_d = 1'b0;
					xor_d        = 8'd0;
				end
			end
			ST_DATA: begin
				if (rx_byte_s1 == FLAG_BYTE) begin
					if (esc_q) begin
						if (held_valid_q) begin
							res_d[0] = '{kind: KIND_PAYLOAD, data: held_q, last: 1'b0};
							n_res    = 2'd1;
						end
						xor_d = xor_q ^ ESC_BYTE;
					end
					res_d[n_res[0]] = '{kind: (xor_d == 8'd0) ? KIND_FRAME_GOOD : KIND_FRAME_BAD,
						data: 8'd0, last: 1'b0};
					n_res        = n_res + 2'd1;
					esc_d        = 1'b0;
					held_d       = 8'd0;
					held_valid_d = 1'b0;
					xor_d        = 8'd0;
				end else if (esc_q || (rx_byte_s1 != ESC_BYTE)) begin
					if (held_valid_q) begin
						res_d[0] = '{kind: KIND_PAYLOAD, data: held_q, last: 1'b0};
						n_res    = 2'd1;
					end
					held_valid_d = 1'b1;
					esc_d        = 1'b0;
					if (!esc_q) begin
						held_d = rx_byte_s1;
						xor_d  = xor_q ^ rx_byte_s1;
					end else if (rx_byte_s1 == ESC_FLAG) begin
						held_d = FLAG_BYTE;
						xor_d  = xor_q ^ FLAG_BYTE;
					end else if (rx_byte_s1 == ESC_ESC || rx_byte_s1 == ESC_BYTE) begin
						held_d = ESC_BYTE;
						xor_d  = xor_q ^ ESC_BYTE;
						esc_d  = (rx_byte_s1 == ESC_BYTE);
					end else begin
						res_d[n_res[0]] = '{kind: KIND_PAYLOAD, data: ESC_BYTE, last: 1'b0};
						n_res  = n_res + 2'd1;
						held_d = rx_byte_s1;
						xor_d  = xor_q ^ ESC_BYTE ^ rx_byte_s1;
					end
				end else begin
					esc_d = 1'b1;
				end
			end
			ST_DISC_FLAG: begin
				if (rx_byte_s1 == FLAG_BYTE) begin
					res_d[0] = '{kind: KIND_DISCONNECT, data: 8'd0, last: 1'b0};
					n_res    = 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (n_res != 2'd0) begin
			res_d[1'(n_res - 2'd1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q    <= 8'd3;
			in_valid_s1  <= 1'b0;
			hdr_q        <= ST_WAIT_FLAG;
			esc_q        <= 1'b0;
			held_q       <= 8'd0;
			held_valid_q <= 1'b0;
			xor_q        <= 8'd0;
			wr_ptr_q     <= 2'd0;
			rd_ptr_q     <= 2'd0;
			count_q      <= 3'd0;
		end else begin
			if (cfg_we) begin
				address_q <= cfg_data;
			end
			if (in_ready) begin
				in_valid_s1 <= in_valid;
			end
			if (fire) begin
				hdr_q        <= hdr_d;
				esc_q        <= esc_d;
				held_q       <= held_d;
				held_valid_q <= held_valid_d;
				xor_q        <= xor_d;
				wr_ptr_q     <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (fire ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
		if (fire && (n_res != 2'd0)) begin
			queue_q[wr_ptr_q] <= res_d[0];
		end
		if (fire && (n_res == 2'd2)) begin
			queue_q[wr_ptr_q + 2'd1] <= res_d[1];
		end
	end

endmodule

[test/tb_info_frame_deframer.sv]
// Self-checking testbench for the information frame deframer with directed and random framing traffic.
`timescale 1ns / 1ps

module tb_info_frame_deframer;

	import ifd_pkg::*;

	localparam logic [7:0] ADDR_AT_RESET = 8'd3;
	localparam int CYCLE_LIMIT = 800000;
	localparam int BYTES_PER_PHASE = 217;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic       last;

	info_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [7:0] line_bytes[$];
	result_t    deframed_q[$];

	int  errors = 0;
	int  cycles = 0;
	bit  in_taken = 1'b0;
	bit  quiet = 1'b0;
	int  hold_requests = 0;
	int  phase_bytes = 0;

	hdr_state_t hdr_st = ST_WAIT_FLAG;
	logic       esc_wait = 1'b0;
	logic [7:0] delay_byte = 8'd0;
	logic       delay_full = 1'b0;
	logic [7:0] frame_xor = 8'd0;
	logic [7:0] addr_reg = ADDR_AT_RESET;
	result_t    step_res[2];
	int         step_n;
	result_t    want;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	task automatic add_result(input logic [1:0] k, input logic [7:0] d);
		step_res[step_n] = '{kind: k, data: d, last: 1'b0};
		step_n++;
	endtask

	task automatic pass_byte(input logic [7:0] d);
		if (delay_full)
			add_result(KIND_PAYLOAD, delay_byte);
		delay_byte = d;
		delay_full = 1'b1;
		frame_xor = frame_xor ^ d;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		step_n = 0;
		case (hdr_st)
			ST_ADDR: begin
				if (b == addr_reg)
					hdr_st = ST_CTRL;
				else if (b == FLAG_BYTE)
					hdr_st = ST_ADDR;
				else
					hdr_st = ST_WAIT_FLAG;
			end
			ST_CTRL: begin
				if (b == CTRL_INFO)
					hdr_st = ST_BCC1;
				else if (b == CTRL_DISC)
					hdr_st = ST_DISC_BCC;
				else if (b == FLAG_BYTE)
					hdr_st = ST_ADDR;
				else
					hdr_st = ST_WAIT_FLAG;
			end
			ST_BCC1: begin
				if (b == (addr_reg ^ CTRL_INFO)) begin
					hdr_st = ST_DATA;
					esc_wait = 1'b0;
					delay_byte = 8'd0;
					delay_full = 1'b0;
					frame_xor = 8'd0;
				end else if (b == FLAG_BYTE) begin
					hdr_st = ST_ADDR;
				end else begin
					hdr_st = ST_WAIT_FLAG;
				end
			end
			ST_DATA: begin
				if (b == FLAG_BYTE) begin
					if (esc_wait) begin
						esc_wait = 1'b0;
						pass_byte(ESC_BYTE);
					end
					add_result((frame_xor == 8'd0) ? KIND_FRAME_GOOD : KIND_FRAME_BAD, 8'd0);
					hdr_st = ST_WAIT_FLAG;
					delay_byte = 8'd0;
					delay_full = 1'b0;
					frame_xor = 8'd0;
				end else if (esc_wait) begin
					esc_wait = 1'b0;
					if (b == ESC_FLAG) begin
						pass_byte(FLAG_BYTE);
					end else if (b == ESC_ESC) begin
						pass_byte(ESC_BYTE);
					end else begin
						pass_byte(ESC_BYTE);
						if (b == ESC_BYTE)
							esc_wait = 1'b1;
						else
							pass_byte(b);
					end
				end else if (b == ESC_BYTE) begin
					esc_wait = 1'b1;
				end else begin
					pass_byte(b);
				end
			end
			ST_DISC_BCC: begin
				if (b == (addr_reg ^ CTRL_DISC))
					hdr_st = ST_DISC_FLAG;
				else if (b == FLAG_BYTE)
					hdr_st = ST_ADDR;
				else
					hdr_st = ST_WAIT_FLAG;
			end
			ST_DISC_FLAG: begin
				if (b == FLAG_BYTE)
					add_result(KIND_DISCONNECT, 8'd0);
				hdr_st = ST_WAIT_FLAG;
			end
			default: begin
				hdr_st = (b == FLAG_BYTE) ? ST_ADDR : ST_WAIT_FLAG;
			end
		endcase
		for (int i = 0; i < step_n; i++) begin
			if (i == step_n - 1)
				step_res[i].last = 1'b1;
			deframed_q.push_back(step_res[i]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_info_frame_deframer: errors");
				$finish;
			end else begin
				if (cfg_we)
					addr_reg = cfg_data;
				if (out_valid && out_ready) begin
					if (deframed_q.size() == 0) begin
						$error("unexpected result: kind %0d payload_byte %02h last %0d",
							kind, payload_byte, last);
						errors++;
					end else begin
						want = deframed_q.pop_front();
						if (kind !== want.kind) begin
							$error("kind: expected %0d, got %0d", want.kind, kind);
							errors++;
						end
						if (payload_byte !== want.data) begin
							$error("payload_byte: expected %02h, got %02h", want.data,
								payload_byte);
							errors++;
						end
						if (last !== want.last) begin
							$error("last: expected %0d, got %0d", want.last, last);
							errors++;
						end
					end
				end
				if (in_valid && in_ready)
					deframe_byte(rx_byte);
			end
		end
		in_taken = arst_n && in_valid && in_ready;
	end

	int send_gap = 0;

	always @(negedge clk) begin : driver
		logic       nv;
		logic [7:0] nb;
		nv = in_valid;
		nb = rx_byte;
		if (in_valid && in_taken)
			nv = 1'b0;
		if (!nv) begin
			nb = 8'($urandom_range(0, 255));
			if (send_gap > 0) begin
				send_gap--;
			end else if (line_bytes.size() != 0) begin
				nb = line_bytes.pop_front();
				nv = 1'b1;
				send_gap = gap_len();
			end
		end
		in_valid <= nv;
		rx_byte <= nb;
	end

	int stall_left = 0;
	int hold_left = 0;
	int holds_done = 0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_done != hold_requests) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			stall_left = gap_len();
		end
	end

	task automatic push_byte(input logic [7:0] b);
		line_bytes.push_back(b);
		phase_bytes++;
	endtask

	task automatic push_stuffed(input logic [7:0] d);
		if (d == FLAG_BYTE) begin
			push_byte(ESC_BYTE);
			push_byte(ESC_FLAG);
		end else if (d == ESC_BYTE) begin
			push_byte(ESC_BYTE);
			push_byte(ESC_ESC);
		end else begin
			push_byte(d);
		end
	endtask

	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return ESC_FLAG;
			3: return ESC_ESC;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic gen_info_frame(input logic [7:0] a);
		int         len;
		int         mode;
		logic [7:0] x;
		logic [7:0] d;
		logic [7:0] odd;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
		mode = $urandom_range(0, 19);
		x = 8'd0;
		push_byte(FLAG_BYTE);
		push_byte(a);
		push_byte(CTRL_INFO);
		push_byte(a ^ CTRL_INFO);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				do
					odd = 8'($urandom_range(0, 255));
				while (odd == ESC_FLAG || odd == ESC_ESC || odd == FLAG_BYTE || odd == ESC_BYTE);
				push_byte(ESC_BYTE);
				push_byte(odd);
				x = x ^ ESC_BYTE ^ odd;
			end else begin
				d = pick_data();
				push_stuffed(d);
				x = x ^ d;
			end
		end
		if (mode < 15)
			push_stuffed(x);
		else if (mode < 17)
			push_stuffed(x ^ 8'($urandom_range(1, 255)));
		else if (mode < 19)
			push_byte(ESC_BYTE);
		push_byte(FLAG_BYTE);
	endtask

	task automatic gen_disconnect(input logic [7:0] a);
		push_byte(FLAG_BYTE);
		push_byte(a);
		push_byte(CTRL_DISC);
		push_byte(a ^ CTRL_DISC);
		if ($urandom_range(0, 6) != 0)
			push_byte(FLAG_BYTE);
		else
			push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic gen_broken_header(input logic [7:0] a);
		int r;
		r = $urandom_range(0, 3);
		push_byte(FLAG_BYTE);
		if (r == 0) begin
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			push_byte(a);
			if (r == 1) begin
				push_byte(8'($urandom_range(0, 255)));
			end else begin
				push_byte((r == 2) ? CTRL_INFO : CTRL_DISC);
				push_byte(($urandom_range(0, 1) == 0) ? FLAG_BYTE : 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic gen_noise(input logic [7:0] a);
		int n;
		int r;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				push_byte(FLAG_BYTE);
			else if (r == 1)
				push_byte(a);
			else
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic write_address(input logic [7:0] v);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (line_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (deframed_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	logic [7:0] directed[24] = '{
		8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E,
		8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h7D, 8'h41,
		8'hFF, 8'h7D, 8'h7E,
		8'h7E, 8'h03, 8'h0B, 8'h08, 8'h7E
	};
	logic [7:0] phase_addr[6];

	initial begin
		int r;
		phase_addr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), FLAG_BYTE,
			8'($urandom_range(0, 255)), ADDR_AT_RESET};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		foreach (directed[i])
			push_byte(directed[i]);
		wait_idle();
		for (int p = 0; p < 6; p++) begin
			write_address(phase_addr[p]);
			@(posedge clk);
			quiet = (p == 2);
			phase_bytes = 0;
			while (phase_bytes < BYTES_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					gen_info_frame(phase_addr[p]);
				else if (r < 70)
					gen_disconnect(phase_addr[p]);
				else if (r < 85)
					gen_broken_header(phase_addr[p]);
				else
					gen_noise(phase_addr[p]);
			end
			if (p == 1 || p == 4)
				hold_requests++;
			wait_idle();
		end
		if (errors == 0)
			$display("tb_info_frame_deframer: clean");
		else
			$display("tb_info_frame_deframer: errors");
		$finish;
	end

endmodule
